>>> rtl/bpf_pkg.sv
// ----------------------------------------------------------------------------
// Bounded packet FIFO package
// Shared widths, request codes and defaults for the packet FIFO core.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int unsigned BPF_DEPTH   = 256;
  localparam int unsigned SRC_W       = 16;
  localparam int unsigned DST_W       = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ENTRY_W     = SRC_W + DST_W + TIME_W;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned LIMIT_W     = 9;
  localparam int unsigned MATCH_W     = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FWD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CNT = 2'd2;

endpackage

>>> rtl/bpf_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface bpf_req_if;
  import bpf_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SRC_W-1:0]    source;
  logic [DST_W-1:0]    dest;
  logic [TIME_W-1:0]   timestamp;
  logic [TIME_W-1:0]   range_low;
  logic [TIME_W-1:0]   range_high;

  modport source_mp (
    output valid, req_type, source, dest, timestamp, range_low, range_high,
    input  ready
  );

  modport sink (
    input  valid, req_type, source, dest, timestamp, range_low, range_high,
    output ready
  );

endinterface

>>> rtl/bpf_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response transaction.
// ----------------------------------------------------------------------------
interface bpf_rsp_if;
  import bpf_pkg::*;

  logic                valid;
  logic                ready;
  logic                accepted;
  logic                out_valid;
  logic [SRC_W-1:0]    out_source;
  logic [DST_W-1:0]    out_dest;
  logic [TIME_W-1:0]   out_time;
  logic [MATCH_W-1:0]  match_count;

  modport source (
    output valid, accepted, out_valid, out_source, out_dest, out_time, match_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, out_valid, out_source, out_dest, out_time, match_count,
    output ready
  );

endinterface

>>> rtl/bpf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bounded_packet_fifo_dedup_count_core.sv
// Flow: an accepted request scans the queue (add reads every entry, count every entry when
// its range is not reversed, forward only the head, unknown codes nothing), then registers its response.
// No new request is taken until that response is registered; the scan reads one RAM word per cycle.
// The response register frees the request side while a response waits.
// Reset: queue empty, limit 256, entry RAM contents undefined until written.
// ----------------------------------------------------------------------------
// Bounded packet FIFO core
// Ring of packets with duplicate filter, oldest-first eviction and a
// destination/time range count, all served by one sequential scan.
// ----------------------------------------------------------------------------
module bounded_packet_fifo_dedup_count_core #(
  parameter int unsigned Depth = bpf_pkg::BPF_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpf_pkg::LIMIT_W-1:0] cfg_wdata_i,
  bpf_req_if.sink                     req_i,
  bpf_rsp_if.source                   rsp_o
);
  import bpf_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [AW-1:0] LAST_IDX  = AW'(Depth - 1);
  localparam logic [LW-1:0] DEPTH_LIM = LW'(Depth);

  logic [1:0]           state_q, state_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        tail_q, tail_d;
  logic [CW-1:0]        occ_q, occ_d;

  logic [REQ_W-1:0]     req_q, req_d;
  logic [ENTRY_W-1:0]   word_q, word_d;
  logic [TIME_W-1:0]    lo_q, lo_d;
  logic [TIME_W-1:0]    hi_q, hi_d;
  logic [CW-1:0]        len_q, len_d;
  logic [CW-1:0]        issued_q, issued_d;
  logic [AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic                 rvalid_q, rvalid_d;
  logic                 dup_q, dup_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [ENTRY_W-1:0]   fwd_q, fwd_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic                 acc_q, acc_d;
  logic                 ov_q, ov_d;
  logic [SRC_W-1:0]     osrc_q, osrc_d;
  logic [DST_W-1:0]     odst_q, odst_d;
  logic [TIME_W-1:0]    otime_q, otime_d;
  logic [MATCH_W-1:0]   mcnt_q, mcnt_d;

  logic                 rd_en;
  logic                 we;
  logic [ENTRY_W-1:0]   rdata;
  logic [LW-1:0]        lim_eff;
  logic                 in_hs;
  logic                 out_free;
  logic [DST_W-1:0]     rd_dst;
  logic [TIME_W-1:0]    rd_time;

  bpf_ram #(
    .Width (ENTRY_W),
    .Depth (Depth),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (word_q),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    lim_eff = LW'(limit_q);
    if (lim_eff == '0) begin
      lim_eff = LW'(1);
    end else if (lim_eff > DEPTH_LIM) begin
      lim_eff = DEPTH_LIM;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign in_hs       = req_i.valid && (state_q == S_IDLE);
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign rd_en       = (state_q == S_SCAN) && (issued_q != len_q);
  assign rd_dst      = rdata[TIME_W +: DST_W];
  assign rd_time     = rdata[TIME_W-1:0];

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    req_d    = req_q;
    word_d   = word_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    len_d    = len_q;
    issued_d = issued_q;
    rd_ptr_d = rd_ptr_q;
    rvalid_d = 1'b0;
    dup_d    = dup_q;
    cnt_d    = cnt_q;
    fwd_d    = fwd_q;
    we       = 1'b0;

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    acc_d       = acc_q;
    ov_d        = ov_q;
    osrc_d      = osrc_q;
    odst_d      = odst_q;
    otime_d     = otime_q;
    mcnt_d      = mcnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          req_d    = req_i.req_type;
          word_d   = {req_i.source, req_i.dest, req_i.timestamp};
          lo_d     = req_i.range_low;
          hi_d     = req_i.range_high;
          issued_d = '0;
          rd_ptr_d = head_q;
          dup_d    = 1'b0;
          cnt_d    = '0;
          fwd_d    = '0;
          case (req_i.req_type)
            REQ_ADD: len_d = occ_q;
            REQ_FWD: len_d = (occ_q != '0) ? CW'(1) : '0;
            REQ_CNT: len_d = (req_i.range_low <= req_i.range_high) ? occ_q : '0;
            default: len_d = '0;
          endcase
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issued_d = issued_q + CW'(1);
          rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          case (req_q)
            REQ_ADD: begin
              if (rdata == word_q) begin
                dup_d = 1'b1;
              end
            end
            REQ_FWD: fwd_d = rdata;
            REQ_CNT: begin
              if (rd_dst == word_q[TIME_W +: DST_W] && rd_time >= lo_q && rd_time <= hi_q) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            default: ;
          endcase
        end
        if (!rd_en && !rvalid_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          acc_d       = 1'b0;
          ov_d        = 1'b0;
          osrc_d      = '0;
          odst_d      = '0;
          otime_d     = '0;
          mcnt_d      = '0;
          case (req_q)
            REQ_ADD: begin
              if (!dup_q) begin
                acc_d  = 1'b1;
                we     = 1'b1;
                tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
                if (LW'(occ_q) >= lim_eff) begin
                  head_d = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
                end else begin
                  occ_d = occ_q + CW'(1);
                end
              end
            end
            REQ_FWD: begin
              if (occ_q != '0) begin
                ov_d    = 1'b1;
                osrc_d  = fwd_q[TIME_W + DST_W +: SRC_W];
                odst_d  = fwd_q[TIME_W +: DST_W];
                otime_d = fwd_q[TIME_W-1:0];
                head_d  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
                occ_d   = occ_q - CW'(1);
              end
            end
            REQ_CNT: mcnt_d = MATCH_W'(cnt_q);
            default: ;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LIMIT_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      rvalid_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      rvalid_q    <= rvalid_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    word_q   <= word_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    len_q    <= len_d;
    issued_q <= issued_d;
    rd_ptr_q <= rd_ptr_d;
    dup_q    <= dup_d;
    cnt_q    <= cnt_d;
    fwd_q    <= fwd_d;
    acc_q    <= acc_d;
    ov_q     <= ov_d;
    osrc_q   <= osrc_d;
    odst_q   <= odst_d;
    otime_q  <= otime_d;
    mcnt_q   <= mcnt_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.accepted    = acc_q;
  assign rsp_o.out_valid   = ov_q;
  assign rsp_o.out_source  = osrc_q;
  assign rsp_o.out_dest    = odst_q;
  assign rsp_o.out_time    = otime_q;
  assign rsp_o.match_count = mcnt_q;

endmodule

>>> dv/bpf_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet FIFO checker
// Watches the request, response and limit ports of the packet FIFO core. It
// keeps its own ring of packets, works out the response to each accepted
// request transaction in order, and compares every accepted response field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bpf_queue_checker
  import bpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i,
  bpf_req_if                  req_i,
  bpf_rsp_if                  rsp_i,
  output int unsigned         error_count_o,
  output int unsigned         pending_count_o,
  output int unsigned         checked_count_o
);

  localparam int unsigned IDX_W = $clog2(BPF_DEPTH);

  typedef struct packed {
    logic                accepted;
    logic                fwd_valid;
    logic [SRC_W-1:0]    src;
    logic [DST_W-1:0]    dst;
    logic [TIME_W-1:0]   tim;
    logic [MATCH_W-1:0]  hits;
  } pkt_result_t;

  logic [ENTRY_W-1:0] ring_q [BPF_DEPTH];
  logic [IDX_W-1:0]   head_q = '0;
  int unsigned        occ_q = 0;
  logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;
  pkt_result_t        pending_results[$];
  int unsigned        n_errors = 0;
  int unsigned        n_checked = 0;

  function automatic int unsigned slot_of(input int unsigned k);
    return (int'(head_q) + k) % BPF_DEPTH;
  endfunction

  function automatic int unsigned held_limit();
    if (limit_q == '0) return 1;
    if (int'(limit_q) > int'(BPF_DEPTH)) return BPF_DEPTH;
    return int'(limit_q);
  endfunction

  function automatic pkt_result_t apply_request(
    input logic [REQ_W-1:0]  kind,
    input logic [SRC_W-1:0]  src,
    input logic [DST_W-1:0]  dst,
    input logic [TIME_W-1:0] tim,
    input logic [TIME_W-1:0] lo,
    input logic [TIME_W-1:0] hi
  );
    pkt_result_t        r;
    logic [ENTRY_W-1:0] word;
    logic               dup;
    int unsigned        cnt;
    r = '0;
    case (kind)
      REQ_ADD: begin
        word = {src, dst, tim};
        dup  = 1'b0;
        for (int unsigned k = 0; k < occ_q; k++) begin
          if (ring_q[slot_of(k)] == word) dup = 1'b1;
        end
        if (!dup) begin
          // drop only the single oldest packet, even if the limit fell further
          if (occ_q >= held_limit() && occ_q != 0) begin
            head_q = head_q + 1'b1;
            occ_q  = occ_q - 1;
          end
          ring_q[slot_of(occ_q)] = word;
          occ_q      = occ_q + 1;
          r.accepted = 1'b1;
        end
      end
      REQ_FWD: begin
        if (occ_q != 0) begin
          {r.src, r.dst, r.tim} = ring_q[head_q];
          r.fwd_valid = 1'b1;
          head_q      = head_q + 1'b1;
          occ_q       = occ_q - 1;
        end
      end
      REQ_CNT: begin
        cnt = 0;
        if (lo <= hi) begin
          for (int unsigned k = 0; k < occ_q; k++) begin
            word = ring_q[slot_of(k)];
            if (word[TIME_W +: DST_W] == dst && word[TIME_W-1:0] >= lo &&
                word[TIME_W-1:0] <= hi) cnt++;
          end
        end
        r.hits = MATCH_W'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pkt_result_t exp_r;
    pkt_result_t new_r;
    if (!rst_ni) begin
      head_q  = '0;
      occ_q   = 0;
      limit_q = LIMIT_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        new_r = apply_request(req_i.req_type, req_i.source, req_i.dest,
                              req_i.timestamp, req_i.range_low, req_i.range_high);
        pending_results.insert(pending_results.size(), new_r);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          $error("response transaction with no request outstanding");
          n_errors++;
        end else begin
          exp_r = pending_results[0];
          pending_results.delete(0);
          n_checked++;
          check_field("accepted", TIME_W'(exp_r.accepted), TIME_W'(rsp_i.accepted));
          check_field("out_valid", TIME_W'(exp_r.fwd_valid), TIME_W'(rsp_i.out_valid));
          check_field("out_source", TIME_W'(exp_r.src), TIME_W'(rsp_i.out_source));
          check_field("out_dest", TIME_W'(exp_r.dst), TIME_W'(rsp_i.out_dest));
          check_field("out_time", exp_r.tim, rsp_i.out_time);
          check_field("match_count", TIME_W'(exp_r.hits), TIME_W'(rsp_i.match_count));
        end
      end
    end
    error_count_o   <= n_errors;
    pending_count_o <= pending_results.size();
    checked_count_o <= n_checked;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet FIFO testbench
// Drives add, forward, count and reserved requests into the packet FIFO core
// in random bursts while the response side stalls on its own pattern. A short
// directed run covers empty and full-scale fields, duplicates and the limit
// corner cases; random phases then run under several limit settings,
// including one above the ring depth. A checker beside the core
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  import bpf_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = BPF_DEPTH + 40;
  localparam int unsigned HISTORY_MAX  = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  bpf_req_if req_ch ();
  bpf_rsp_if rsp_ch ();

  int unsigned        error_count;
  int unsigned        pending_count;
  int unsigned        checked_count;
  int unsigned        burst_left = 0;
  int unsigned        n_add = 0;
  int unsigned        n_fwd = 0;
  int unsigned        n_cnt = 0;
  int unsigned        n_rsv = 0;
  int unsigned        n_limits = 0;
  logic [ENTRY_W-1:0] added_history[$];

  bounded_packet_fifo_dedup_count_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  bpf_queue_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .req_i           (req_ch),
    .rsp_i           (rsp_ch),
    .error_count_o   (error_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SRC_W-1:0] pick_id();
    if ($urandom_range(0, 1) == 0) return SRC_W'($urandom_range(0, 3));
    return SRC_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return TIME_W'($urandom_range(0, 15));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  task automatic drive(input logic [REQ_W-1:0] kind, input logic [SRC_W-1:0] src,
                       input logic [DST_W-1:0] dst, input logic [TIME_W-1:0] tim,
                       input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
    int unsigned gap;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.source     <= src;
    req_ch.dest       <= dst;
    req_ch.timestamp  <= tim;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    burst_left--;
    case (kind)
      REQ_ADD: n_add++;
      REQ_FWD: n_fwd++;
      REQ_CNT: n_cnt++;
      default: n_rsv++;
    endcase
  endtask

  // hold the request side until every response is back, then write the limit
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_limits++;
  endtask

  task automatic random_request(input int unsigned add_pct, input int unsigned fwd_pct);
    int unsigned        roll;
    logic [SRC_W-1:0]   src;
    logic [DST_W-1:0]   dst;
    logic [TIME_W-1:0]  tim;
    logic [TIME_W-1:0]  lo;
    logic [TIME_W-1:0]  hi;
    roll = $urandom_range(0, 99);
    src  = pick_id();
    dst  = pick_id();
    tim  = pick_time();
    lo   = TIME_W'($urandom);
    hi   = TIME_W'($urandom);
    if (roll < 3) begin
      drive(REQ_RESERVED, src, dst, tim, lo, hi);
    end else if (roll < 3 + add_pct) begin
      if (added_history.size() != 0 && $urandom_range(0, 4) == 0) begin
        {src, dst, tim} = added_history[$urandom_range(0, added_history.size() - 1)];
      end else begin
        added_history.insert(added_history.size(), {src, dst, tim});
        if (added_history.size() > HISTORY_MAX) added_history.delete(0);
      end
      drive(REQ_ADD, src, dst, tim, lo, hi);
    end else if (roll < 3 + add_pct + fwd_pct) begin
      drive(REQ_FWD, src, dst, tim, lo, hi);
    end else begin
      if (added_history.size() != 0 && $urandom_range(0, 2) != 0) begin
        dst = added_history[$urandom_range(0, added_history.size() - 1)][TIME_W +: DST_W];
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          lo = TIME_W'($urandom_range(0, 15));
          hi = lo + TIME_W'($urandom_range(0, 8));
        end
        4: begin
          lo = '0;
          hi = '1;
        end
        5: begin
          hi = TIME_W'($urandom_range(0, 14));
          lo = hi + TIME_W'($urandom_range(1, 8));
        end
        6: begin
          lo = pick_time();
          hi = lo;
        end
        default: if (lo > hi) {lo, hi} = {hi, lo};
      endcase
      drive(REQ_CNT, src, dst, tim, lo, hi);
    end
  endtask

  // receiver: switch between free flow, random, heavy and periodic stalls
  initial begin
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned phase;
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    stall_mode   = 0;
    phase        = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      phase++;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= (phase % 3 != 0);
      endcase
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ADD;
    req_ch.source     = '0;
    req_ch.dest       = '0;
    req_ch.timestamp  = '0;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, extreme fields, duplicates and reserved code
    drive(REQ_FWD, '1, '1, '1, '1, '1);
    drive(REQ_CNT, '0, '0, '0, '0, '1);
    drive(REQ_ADD, '0, '0, '0, '0, '0);
    drive(REQ_ADD, '1, '1, '1, '1, '1);
    drive(REQ_ADD, '1, '1, '1, '0, '0);
    drive(REQ_ADD, '0, '0, '0, '1, '1);
    drive(REQ_CNT, '0, '1, '0, '0, '1);
    drive(REQ_CNT, '1, '0, '1, '0, '0);
    drive(REQ_CNT, '0, '0, '0, 32'd1, '0);
    drive(REQ_CNT, '0, '1, '0, '1, '1);
    drive(REQ_RESERVED, '1, '1, '1, '1, '1);
    drive(REQ_FWD, '0, '0, '0, '0, '0);
    drive(REQ_FWD, '0, '0, '0, '0, '0);
    drive(REQ_FWD, '0, '0, '0, '0, '0);

    // zero limit acts as one
    set_limit('0);
    drive(REQ_ADD, 16'd1, 16'd2, 32'd3, '0, '0);
    drive(REQ_ADD, 16'd4, 16'd5, 32'd6, '0, '0);
    drive(REQ_FWD, '0, '0, '0, '0, '0);

    // lower the limit beneath the occupancy
    set_limit(9'd256);
    for (int unsigned i = 1; i <= 5; i++) begin
      drive(REQ_ADD, SRC_W'(i), 16'd7, TIME_W'(100 + i), '0, '0);
    end
    set_limit(9'd2);
    drive(REQ_ADD, 16'd9, 16'd7, 32'd106, '0, '0);
    drive(REQ_CNT, '0, 16'd7, '0, 32'd100, 32'd110);

    set_limit('1);
    repeat (40) random_request(50, 20);

    // add 250 packets under a limit above the ring depth
    set_limit(9'd300);
    repeat (250) drive(REQ_ADD, SRC_W'($urandom), pick_id(), TIME_W'($urandom),
                       TIME_W'($urandom), TIME_W'($urandom));
    repeat (10) random_request(30, 10);

    set_limit(9'd1);
    repeat (25) random_request(50, 25);
    set_limit(9'd5);
    repeat (40) random_request(45, 20);
    set_limit(9'd16);
    repeat (30) random_request(45, 20);
    set_limit('0);
    repeat (15) random_request(50, 20);
    set_limit(9'd256);
    repeat (30) random_request(40, 15);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d adds, %0d forwards, %0d counts, %0d reserved under %0d limit writes",
             n_add, n_fwd, n_cnt, n_rsv, n_limits);
    $display("Compared %0d responses, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bpf_pkg.sv
rtl/bpf_req_if.sv
rtl/bpf_rsp_if.sv
rtl/bpf_ram.sv
rtl/bounded_packet_fifo_dedup_count_core.sv
dv/bpf_queue_checker.sv
dv/tb.sv
